// ===== hdl/ece_pkg.sv =====
`timescale 1ns / 1ps

package ece_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int BISECT_STEPS_DEF = 24;

  // t, u and the bisection bounds live in [0, ONE]
  localparam int T_W     = FRAC_BITS + 1;
  localparam int CTRL_W  = 18;
  localparam int OUT_W   = 17;
  localparam int SEL_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 2 * MUL_W - 2;
  localparam int COORD_W = 22;

  typedef logic [T_W-1:0]                ufix_t;
  typedef logic signed [MUL_W-1:0]       mul_t;
  typedef logic signed [CTRL_W-1:0]      ctrl_t;
  typedef logic signed [COORD_W-1:0]     coord_t;

  localparam ufix_t ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int    OUT_MAX = (1 << OUT_W) - 1;

  localparam longint NANO = 64'd1000000000;

  localparam mul_t SIN_A  = mul_t'(((longint'(1570796327) << FRAC_BITS) + NANO / 2) / NANO);
  localparam mul_t SIN_B  = mul_t'(((longint'(641592654) << FRAC_BITS) + NANO / 2) / NANO);
  localparam mul_t SIN_C  = mul_t'(((longint'(70796327) << FRAC_BITS) + NANO / 2) / NANO);
  localparam mul_t EXP_A  = mul_t'(((longint'(695957000) << FRAC_BITS) + NANO / 2) / NANO);
  localparam mul_t EXP_B  = mul_t'(((longint'(224845000) << FRAC_BITS) + NANO / 2) / NANO);
  localparam mul_t EXP_C  = mul_t'(((longint'(79198000) << FRAC_BITS) + NANO / 2) / NANO);
  localparam mul_t BACK_1 = mul_t'(((longint'(1701580000) << FRAC_BITS) + NANO / 2) / NANO);
  localparam mul_t BACK_3 = mul_t'(((longint'(1701580000) << FRAC_BITS) + NANO / 2) / NANO
                                   + (longint'(1) << FRAC_BITS));

  typedef enum logic [SEL_W-1:0] {
    CURVE_LINEAR    = 4'd0,
    CURVE_CUBIC_IN  = 4'd1,
    CURVE_CUBIC_OUT = 4'd2,
    CURVE_SMOOTH    = 4'd3,
    CURVE_BACK      = 4'd4,
    CURVE_OUT_CUBIC = 4'd5,
    CURVE_SPRING    = 4'd6,
    CURVE_BOUNCE    = 4'd7,
    CURVE_STEP      = 4'd8,
    CURVE_BEZIER    = 4'd9
  } curve_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CTRL1_X = 3'd0,
    CFG_CTRL1_Y = 3'd1,
    CFG_CTRL2_X = 3'd2,
    CFG_CTRL2_Y = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    ctrl_t x1;
    ctrl_t y1;
    ctrl_t x2;
    ctrl_t y2;
  } ctrl_pts_t;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    ufix_t            t;
    ufix_t            lo;
    ufix_t            hi;
  } bez_item_t;

  function automatic mul_t to_mul(input ufix_t x);
    return mul_t'({{(MUL_W - T_W){1'b0}}, x});
  endfunction

  // Fixed-point product, rounded to nearest with ties away from zero
  function automatic mul_t fmul(input mul_t a, input mul_t b);
    mul_t              na;
    mul_t              nb;
    mul_t              res;
    logic [MUL_W-2:0]  ma;
    logic [MUL_W-2:0]  mb;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rnd;
    na   = -a;
    nb   = -b;
    ma   = a[MUL_W-1] ? na[MUL_W-2:0] : a[MUL_W-2:0];
    mb   = b[MUL_W-1] ? nb[MUL_W-2:0] : b[MUL_W-2:0];
    prod = ma * mb;
    rnd  = (prod + ({{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1))) >> FRAC_BITS;
    res  = mul_t'(rnd[MUL_W-1:0]);
    return (a[MUL_W-1] ^ b[MUL_W-1]) ? -res : res;
  endfunction

endpackage

// ===== hdl/ece_req_if.sv =====
`timescale 1ns / 1ps

interface ece_req_if;
  import ece_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SEL_W-1:0]        curve_select;
  logic signed [CTRL_W-1:0] progress;

  modport source (output valid, curve_select, progress, input ready);
  modport sink   (input valid, curve_select, progress, output ready);
endinterface

// ===== hdl/ece_rsp_if.sv =====
`timescale 1ns / 1ps

interface ece_rsp_if;
  import ece_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] eased_value;

  modport source (output valid, eased_value, input ready);
  modport sink   (input valid, eased_value, output ready);
endinterface

// ===== hdl/ece_bez_stage.sv =====
`timescale 1ns / 1ps

module ece_bez_stage #(
  parameter bit FINAL = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ece_pkg::bez_item_t item_i,
  input  ece_pkg::ctrl_t     p1_i,
  input  ece_pkg::ctrl_t     p2_i,
  output logic               valid_o,
  output ece_pkg::bez_item_t item_o,
  output ece_pkg::coord_t    coord_o
);
  import ece_pkg::*;

  logic [T_W:0] sum;
  ufix_t        mid;
  ufix_t        rem;
  mul_t         u2_d, mm_d;
  mul_t         f1, f2;

  logic      a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  bez_item_t a_item_q, b_item_q, c_item_q, d_item_q;
  ufix_t     a_u_q, a_m_q, b_u_q, c_u_q;
  mul_t      a_u2_q, a_mm_q;
  mul_t      b_b1_q, b_b2_q, b_b3_q;
  mul_t      c_y1_q, c_y2_q, c_b3_q;
  coord_t    d_coord_q;

  coord_t    coord_d;
  bez_item_t item_d;

  // Stage A: midpoint and first squares
  always_comb begin
    sum  = {1'b0, item_i.lo} + {1'b0, item_i.hi};
    mid  = sum[T_W:1];
    rem  = ONE - mid;
    u2_d = fmul(to_mul(mid), to_mul(mid));
    mm_d = fmul(to_mul(rem), to_mul(rem));
  end

  // Stage B: Bernstein weights
  always_comb begin
    f1 = fmul(a_mm_q, to_mul(a_u_q));
    f2 = fmul(to_mul(a_m_q), a_u2_q);
  end

  // Stage D: sum and narrow the bracket
  always_comb begin
    coord_d = coord_t'(c_y1_q + c_y2_q + c_b3_q);
    item_d  = c_item_q;
    if (!FINAL) begin
      if (coord_d < coord_t'(c_item_q.t)) begin
        item_d.lo = c_u_q;
      end else begin
        item_d.hi = c_u_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_item_q  <= item_i;
      a_u_q     <= mid;
      a_m_q     <= rem;
      a_u2_q    <= u2_d;
      a_mm_q    <= mm_d;
      b_item_q  <= a_item_q;
      b_u_q     <= a_u_q;
      b_b1_q    <= (f1 <<< 1) + f1;
      b_b2_q    <= (f2 <<< 1) + f2;
      b_b3_q    <= fmul(a_u2_q, to_mul(a_u_q));
      c_item_q  <= b_item_q;
      c_u_q     <= b_u_q;
      c_y1_q    <= fmul(b_b1_q, mul_t'(p1_i));
      c_y2_q    <= fmul(b_b2_q, mul_t'(p2_i));
      c_b3_q    <= b_b3_q;
      d_item_q  <= item_d;
      d_coord_q <= coord_d;
    end
  end

  assign valid_o = d_valid_q;
  assign item_o  = d_item_q;
  assign coord_o = d_coord_q;
endmodule

// ===== hdl/ece_curves.sv =====
`timescale 1ns / 1ps

module ece_curves (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [ece_pkg::SEL_W-1:0]    sel_i,
  input  ece_pkg::ufix_t               t_i,
  input  ece_pkg::coord_t              bez_i,
  output logic                         valid_o,
  output logic [ece_pkg::OUT_W-1:0]    value_o
);
  import ece_pkg::*;

  localparam int PH_W = T_W + 4;
  localparam int W_W  = FRAC_BITS + 3;

  localparam logic [PH_W-1:0] LIM_A = PH_W'(4) << FRAC_BITS;
  localparam logic [PH_W-1:0] LIM_B = PH_W'(8) << FRAC_BITS;
  localparam logic [PH_W-1:0] LIM_C = PH_W'(10) << FRAC_BITS;
  localparam logic [PH_W:0]   K_B   = (PH_W + 1)'(12) << FRAC_BITS;
  localparam logic [PH_W:0]   K_C   = (PH_W + 1)'(18) << FRAC_BITS;
  localparam logic [PH_W:0]   K_D   = (PH_W + 1)'(21) << FRAC_BITS;
  localparam ufix_t OFF_B = ufix_t'((3 << FRAC_BITS) / 4);
  localparam ufix_t OFF_C = ufix_t'((15 << FRAC_BITS) / 16);
  localparam ufix_t OFF_D = ufix_t'((63 << FRAC_BITS) / 64);
  localparam logic [2*W_W-1:0] BNC_RND = (2 * W_W)'(1) << (FRAC_BITS + 5);

  // ---- stage 0: phase, exponent split, bounce segment
  ufix_t            u_d, q, qs_d, x_d, off_d;
  logic [PH_W-1:0]  ph, e, t11;
  logic [PH_W:0]    t22, kone, diff;
  logic [1:0]       quad_d;
  logic [3:0]       n_d;

  always_comb begin
    u_d    = ONE - t_i;
    ph     = ({4'b0, u_d} << 3) + ({4'b0, u_d} << 2) + {4'b0, u_d};
    quad_d = ph[FRAC_BITS+1:FRAC_BITS];
    q      = {1'b0, ph[FRAC_BITS-1:0]};
    qs_d   = quad_d[0] ? ONE - q : q;
    e      = ({4'b0, u_d} << 3) + ({4'b0, u_d} << 1);
    n_d    = e[FRAC_BITS+3:FRAC_BITS];
    x_d    = ONE - {1'b0, e[FRAC_BITS-1:0]};
    t11    = ({4'b0, t_i} << 3) + ({4'b0, t_i} << 1) + {4'b0, t_i};
    t22    = {t11, 1'b0};
    priority if (t11 < LIM_A) begin
      kone  = '0;
      off_d = '0;
    end else if (t11 < LIM_B) begin
      kone  = K_B;
      off_d = OFF_B;
    end else if (t11 < LIM_C) begin
      kone  = K_C;
      off_d = OFF_C;
    end else begin
      kone  = K_D;
      off_d = OFF_D;
    end
    diff = (t22 >= kone) ? t22 - kone : kone - t22;
  end

  logic             p0_valid_q;
  logic [SEL_W-1:0] p0_sel_q;
  ufix_t            p0_t_q, p0_u_q, p0_qs_q, p0_x_q, p0_off_q;
  logic [1:0]       p0_quad_q;
  logic [3:0]       p0_n_q;
  logic [W_W-1:0]   p0_w_q;
  coord_t           p0_bez_q;

  // ---- stage 1: squares, first polynomial terms, bounce
  logic [2*W_W-1:0] wsq, bsh;
  always_comb begin
    wsq = p0_w_q * p0_w_q;
    bsh = (wsq + BNC_RND) >> (FRAC_BITS + 6);
  end

  logic             p1_valid_q;
  logic [SEL_W-1:0] p1_sel_q;
  ufix_t            p1_t_q, p1_u_q, p1_qs_q, p1_x_q;
  mul_t             p1_tt_q, p1_uu_q, p1_q2_q, p1_pa_q, p1_bnc_q;
  logic [1:0]       p1_quad_q;
  logic [3:0]       p1_n_q;
  coord_t           p1_bez_q;

  // ---- stage 2: cubes, sine inner term, exponent second term
  logic             p2_valid_q;
  logic [SEL_W-1:0] p2_sel_q;
  ufix_t            p2_t_q, p2_qs_q, p2_x_q;
  mul_t             p2_tt_q, p2_uu_q, p2_t3_q, p2_u3_q, p2_q2_q, p2_inner_q, p2_pb_q;
  mul_t             p2_bnc_q;
  logic [1:0]       p2_quad_q;
  logic [3:0]       p2_n_q;
  coord_t           p2_bez_q;

  // ---- stage 3: pick the plain curves, back and spring products
  mul_t r3_d;
  always_comb begin
    unique case (curve_e'(p2_sel_q))
      CURVE_CUBIC_IN:                   r3_d = p2_t3_q;
      CURVE_CUBIC_OUT, CURVE_OUT_CUBIC: r3_d = to_mul(ONE) - p2_u3_q;
      CURVE_SMOOTH:  r3_d = (p2_tt_q <<< 1) + p2_tt_q - (p2_t3_q <<< 1);
      CURVE_BOUNCE:  r3_d = p2_bnc_q;
      CURVE_STEP:    r3_d = (p2_t_q == ONE) ? to_mul(ONE) : '0;
      CURVE_BEZIER:  r3_d = mul_t'(p2_bez_q);
      default:       r3_d = to_mul(p2_t_q);
    endcase
  end

  logic             p3_valid_q;
  logic [SEL_W-1:0] p3_sel_q;
  ufix_t            p3_t_q, p3_qs_q;
  mul_t             p3_r_q, p3_bk3_q, p3_bk1_q, p3_sq_q, p3_g_q;
  logic [1:0]       p3_quad_q;
  logic [3:0]       p3_n_q;

  // ---- stage 4: back curve, sine value, envelope shift
  mul_t           back, s_val, r4_d, wave_d;
  logic [T_W+1:0] gsum, envs;
  logic [4:0]     shamt;
  always_comb begin
    back = to_mul(ONE) - p3_bk3_q + p3_bk1_q;
    if (back > to_mul(ONE)) begin
      back = to_mul(ONE);
    end
    r4_d   = (curve_e'(p3_sel_q) == CURVE_BACK) ? back : p3_r_q;
    s_val  = fmul(to_mul(p3_qs_q), SIN_A + p3_sq_q);
    wave_d = p3_quad_q[1] ? -s_val : s_val;
    gsum   = {1'b0, p3_g_q[T_W:0]} + ((T_W + 2)'(1) << p3_n_q);
    shamt  = {1'b0, p3_n_q} + 5'd1;
    envs   = gsum >> shamt;
  end

  logic             p4_valid_q;
  logic [SEL_W-1:0] p4_sel_q;
  ufix_t            p4_t_q, p4_env_q;
  mul_t             p4_r_q, p4_wave_q;

  logic             p5_valid_q;
  logic [SEL_W-1:0] p5_sel_q;
  ufix_t            p5_t_q;
  mul_t             p5_r_q, p5_spr_q;

  // ---- output: spring endpoints and saturation
  mul_t             r6;
  logic [OUT_W-1:0] out_d;
  always_comb begin
    r6 = p5_r_q;
    if (curve_e'(p5_sel_q) == CURVE_SPRING) begin
      priority if (p5_t_q == '0) begin
        r6 = '0;
      end else if (p5_t_q == ONE) begin
        r6 = to_mul(ONE);
      end else begin
        r6 = p5_spr_q;
      end
    end
    priority if (r6 < 0) begin
      out_d = '0;
    end else if (r6 > mul_t'(OUT_MAX)) begin
      out_d = OUT_W'(OUT_MAX);
    end else begin
      out_d = r6[OUT_W-1:0];
    end
  end

  logic             out_valid_q;
  logic [OUT_W-1:0] out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_valid_q  <= 1'b0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      p3_valid_q  <= 1'b0;
      p4_valid_q  <= 1'b0;
      p5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      p0_valid_q  <= valid_i;
      p1_valid_q  <= p0_valid_q;
      p2_valid_q  <= p1_valid_q;
      p3_valid_q  <= p2_valid_q;
      p4_valid_q  <= p3_valid_q;
      p5_valid_q  <= p4_valid_q;
      out_valid_q <= p5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_sel_q   <= sel_i;
      p0_t_q     <= t_i;
      p0_u_q     <= u_d;
      p0_qs_q    <= qs_d;
      p0_x_q     <= x_d;
      p0_off_q   <= off_d;
      p0_quad_q  <= quad_d;
      p0_n_q     <= n_d;
      p0_w_q     <= diff[W_W-1:0];
      p0_bez_q   <= bez_i;

      p1_sel_q   <= p0_sel_q;
      p1_t_q     <= p0_t_q;
      p1_u_q     <= p0_u_q;
      p1_qs_q    <= p0_qs_q;
      p1_x_q     <= p0_x_q;
      p1_quad_q  <= p0_quad_q;
      p1_n_q     <= p0_n_q;
      p1_bez_q   <= p0_bez_q;
      p1_tt_q    <= fmul(to_mul(p0_t_q), to_mul(p0_t_q));
      p1_uu_q    <= fmul(to_mul(p0_u_q), to_mul(p0_u_q));
      p1_q2_q    <= fmul(to_mul(p0_qs_q), to_mul(p0_qs_q));
      p1_pa_q    <= EXP_B + fmul(to_mul(p0_x_q), EXP_C);
      p1_bnc_q   <= to_mul(bsh[T_W-1:0]) + to_mul(p0_off_q);

      p2_sel_q   <= p1_sel_q;
      p2_t_q     <= p1_t_q;
      p2_qs_q    <= p1_qs_q;
      p2_x_q     <= p1_x_q;
      p2_quad_q  <= p1_quad_q;
      p2_n_q     <= p1_n_q;
      p2_bez_q   <= p1_bez_q;
      p2_tt_q    <= p1_tt_q;
      p2_uu_q    <= p1_uu_q;
      p2_q2_q    <= p1_q2_q;
      p2_bnc_q   <= p1_bnc_q;
      p2_t3_q    <= fmul(p1_tt_q, to_mul(p1_t_q));
      p2_u3_q    <= fmul(p1_uu_q, to_mul(p1_u_q));
      p2_inner_q <= fmul(p1_q2_q, SIN_C) - SIN_B;
      p2_pb_q    <= EXP_A + fmul(to_mul(p1_x_q), p1_pa_q);

      p3_sel_q   <= p2_sel_q;
      p3_t_q     <= p2_t_q;
      p3_qs_q    <= p2_qs_q;
      p3_quad_q  <= p2_quad_q;
      p3_n_q     <= p2_n_q;
      p3_r_q     <= r3_d;
      p3_bk3_q   <= fmul(BACK_3, p2_u3_q);
      p3_bk1_q   <= fmul(BACK_1, p2_uu_q);
      p3_sq_q    <= fmul(p2_q2_q, p2_inner_q);
      p3_g_q     <= to_mul(ONE) + fmul(to_mul(p2_x_q), p2_pb_q);

      p4_sel_q   <= p3_sel_q;
      p4_t_q     <= p3_t_q;
      p4_r_q     <= r4_d;
      p4_wave_q  <= wave_d;
      p4_env_q   <= envs[T_W-1:0];

      p5_sel_q   <= p4_sel_q;
      p5_t_q     <= p4_t_q;
      p5_r_q     <= p4_r_q;
      p5_spr_q   <= to_mul(ONE) - fmul(p4_wave_q, to_mul(p4_env_q));

      out_value_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign value_o = out_value_q;
endmodule

// ===== hdl/easing_curve_evaluator.sv =====
`timescale 1ns / 1ps

// Easing curve evaluator.
// Requests arrive on req_i (curve_select, progress in signed Q2.16) and
// results leave on rsp_o (eased_value in unsigned Q1.16, saturated). Both
// use a valid/ready handshake; a request moves on a clock edge where valid
// and ready are both high.
// The four Bezier control points are written through cfg_we_i, cfg_idx_i
// and cfg_wdata_i; the user must write them only while no request is in
// flight, which the block does not enforce. Indexes beyond three are dropped.
// There are 24 bisection steps by default; each is four register stages
// of its own, followed by four stages for the final Bezier y and seven
// for the other curves and the output register. Throughput is one
// request per cycle unless a result waits on a stalled receiver.
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and req_i.ready drops in the same cycle; nothing is lost.
// Reset clears all valid bits and loads the control points (0,0), (1,1).
module easing_curve_evaluator #(
  parameter int BISECT_STEPS = ece_pkg::BISECT_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ece_req_if.sink                         req_i,
  ece_rsp_if.source                       rsp_o,
  input  logic                            cfg_we_i,
  input  logic [ece_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ece_pkg::CTRL_W-1:0]      cfg_wdata_i
);
  import ece_pkg::*;

  ctrl_pts_t ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.x1 <= '0;
      ctrl_q.y1 <= '0;
      ctrl_q.x2 <= ctrl_t'(ONE);
      ctrl_q.y2 <= ctrl_t'(ONE);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_CTRL1_X: ctrl_q.x1 <= ctrl_t'(cfg_wdata_i);
        CFG_CTRL1_Y: ctrl_q.y1 <= ctrl_t'(cfg_wdata_i);
        CFG_CTRL2_X: ctrl_q.x2 <= ctrl_t'(cfg_wdata_i);
        CFG_CTRL2_Y: ctrl_q.y2 <= ctrl_t'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  logic  en;
  ufix_t t_clamp;

  // advance everything unless a result is waiting on a stalled receiver
  assign en          = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = en;

  always_comb begin
    priority if (req_i.progress[CTRL_W-1]) begin
      t_clamp = '0;
    end else if (req_i.progress[CTRL_W-2:0] > ONE) begin
      t_clamp = ONE;
    end else begin
      t_clamp = req_i.progress[CTRL_W-2:0];
    end
  end

  bez_item_t         chain_item [BISECT_STEPS+1];
  logic [BISECT_STEPS:0] chain_valid;

  assign chain_valid[0]     = req_i.valid;
  assign chain_item[0].sel  = req_i.curve_select;
  assign chain_item[0].t    = t_clamp;
  assign chain_item[0].lo   = '0;
  assign chain_item[0].hi   = ONE;

  for (genvar i = 0; i < BISECT_STEPS; i++) begin : g_step
    ece_bez_stage #(
      .FINAL (1'b0)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .item_i  (chain_item[i]),
      .p1_i    (ctrl_q.x1),
      .p2_i    (ctrl_q.x2),
      .valid_o (chain_valid[i+1]),
      .item_o  (chain_item[i+1]),
      .coord_o ()
    );
  end

  logic      ev_valid;
  bez_item_t ev_item;
  coord_t    ev_coord;

  ece_bez_stage #(
    .FINAL (1'b1)
  ) u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_valid[BISECT_STEPS]),
    .item_i  (chain_item[BISECT_STEPS]),
    .p1_i    (ctrl_q.y1),
    .p2_i    (ctrl_q.y2),
    .valid_o (ev_valid),
    .item_o  (ev_item),
    .coord_o (ev_coord)
  );

  ece_curves u_curves (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ev_valid),
    .sel_i   (ev_item.sel),
    .t_i     (ev_item.t),
    .bez_i   (ev_coord),
    .valid_o (rsp_o.valid),
    .value_o (rsp_o.eased_value)
  );

  a_stall_blocks_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !req_i.ready)
    else $error("request taken while a result is stalled");

  a_empty_takes_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_o.valid |-> req_i.ready)
    else $error("request refused with no result pending");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready && !cfg_we_i) |=> $stable(ctrl_q) && !$rose(req_i.ready && req_i.valid && !rsp_o.valid))
    else $error("pipeline moved during a stall");
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ece_pkg::*;

  localparam int  LATENCY   = 4 * (BISECT_STEPS_DEF + 1) + 7;
  localparam int  DOG_LIMIT = 5000;
  localparam longint Q_ONE  = 64'sd65536;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CTRL_W-1:0]    cfg_wdata_i;

  ece_req_if req_if ();
  ece_rsp_if rsp_if ();

  easing_curve_evaluator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // control points as seen by the predictor
  longint pt1_x, pt1_y, pt2_x, pt2_y;

  logic [OUT_W-1:0] eased_q[$];
  int               mismatches;
  int               results_seen;
  int               idle_cycles;

  typedef struct {
    logic [SEL_W-1:0]  sel;
    logic [CTRL_W-1:0] t;
    bit                typed;
    logic [OUT_W-1:0]  value;
  } vec_t;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint qconst(input longint nano);
    return ((nano << FRAC_BITS) + 64'sd500000000) / 64'sd1000000000;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    longint ma, mb, r;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    r  = (ma * mb + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint quarter_sine(input longint q);
    longint q2, inner;
    q2    = fx_mul(q, q);
    inner = -qconst(641592654) + fx_mul(q2, qconst(70796327));
    return fx_mul(q, qconst(1570796327) + fx_mul(q2, inner));
  endfunction

  function automatic longint pow2_poly(input longint x);
    longint p;
    p = qconst(224845000) + fx_mul(x, qconst(79198000));
    p = qconst(695957000) + fx_mul(x, p);
    return Q_ONE + fx_mul(x, p);
  endfunction

  function automatic longint spring_at(input longint t);
    longint v, ph, q, wave, e, g, env;
    int quad, n;
    if (t <= 0) return 0;
    if (t >= Q_ONE) return Q_ONE;
    v    = Q_ONE - t;
    ph   = 13 * v;
    quad = int'((ph >>> FRAC_BITS) & 3);
    q    = ph & (Q_ONE - 1);
    wave = quarter_sine(quad[0] ? Q_ONE - q : q);
    if (quad[1]) wave = -wave;
    e    = 10 * v;
    n    = int'(e >>> FRAC_BITS);
    g    = pow2_poly(Q_ONE - (e & (Q_ONE - 1)));
    env  = (g + (64'sd1 << n)) >>> (n + 1);
    return Q_ONE - fx_mul(wave, env);
  endfunction

  function automatic longint bounce_at(input longint t);
    longint k, off, s;
    if (11 * t < 4 * Q_ONE) begin
      k = 0;  off = 0;
    end else if (11 * t < 8 * Q_ONE) begin
      k = 12; off = (Q_ONE * 3) / 4;
    end else if (11 * t < 10 * Q_ONE) begin
      k = 18; off = (Q_ONE * 15) / 16;
    end else begin
      k = 21; off = (Q_ONE * 63) / 64;
    end
    s = 22 * t - k * Q_ONE;
    if (s < 0) s = -s;
    return ((s * s + (64'sd1 << (FRAC_BITS + 5))) >>> (FRAC_BITS + 6)) + off;
  endfunction

  function automatic longint bez_axis(input longint u, input longint p1, input longint p2);
    longint m, u2, b1, b2, b3;
    m  = Q_ONE - u;
    u2 = fx_mul(u, u);
    b1 = 3 * fx_mul(fx_mul(m, m), u);
    b2 = 3 * fx_mul(m, u2);
    b3 = fx_mul(u2, u);
    return fx_mul(b1, p1) + fx_mul(b2, p2) + b3;
  endfunction

  function automatic longint bezier_at(input longint t);
    longint lo, hi, mid;
    lo = 0;
    hi = Q_ONE;
    for (int i = 0; i < BISECT_STEPS_DEF; i++) begin
      mid = (lo + hi) >>> 1;
      if (bez_axis(mid, pt1_x, pt2_x) < t) lo = mid;
      else hi = mid;
    end
    return bez_axis((lo + hi) >>> 1, pt1_y, pt2_y);
  endfunction

  function automatic logic [OUT_W-1:0] eased_of(input logic [SEL_W-1:0] sel,
                                                input logic [CTRL_W-1:0] raw);
    longint t, r, u, u2, u3;
    t = longint'(signed'(raw));
    if (t < 0) t = 0;
    if (t > Q_ONE) t = Q_ONE;
    case (sel)
      CURVE_CUBIC_IN: r = fx_mul(fx_mul(t, t), t);
      CURVE_CUBIC_OUT, CURVE_OUT_CUBIC: begin
        u = Q_ONE - t;
        r = Q_ONE - fx_mul(fx_mul(u, u), u);
      end
      CURVE_SMOOTH: begin
        u2 = fx_mul(t, t);
        r  = 3 * u2 - 2 * fx_mul(u2, t);
      end
      CURVE_BACK: begin
        u  = t - Q_ONE;
        u2 = fx_mul(u, u);
        u3 = fx_mul(u2, u);
        r  = Q_ONE + fx_mul(qconst(1701580000) + Q_ONE, u3)
             + fx_mul(qconst(1701580000), u2);
        if (r > Q_ONE) r = Q_ONE;
      end
      CURVE_SPRING: r = spring_at(t);
      CURVE_BOUNCE: r = bounce_at(t);
      CURVE_STEP:   r = t < Q_ONE ? 0 : Q_ONE;
      CURVE_BEZIER: r = bezier_at(t);
      default:      r = t;
    endcase
    if (r < 0) r = 0;
    if (r > OUT_MAX) r = OUT_MAX;
    return r[OUT_W-1:0];
  endfunction

  // track accepted requests and check results
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    if (req_if.valid && req_if.ready) begin
      eased_q = {eased_q, eased_of(req_if.curve_select, req_if.progress)};
    end
    if (rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (eased_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result eased_value=%0d", $time, rsp_if.eased_value);
      end else begin
        want = eased_q.pop_front();
        if (rsp_if.eased_value !== want) begin
          mismatches++;
          $display("%0t: eased_value expected %0d actual %0d", $time, want,
                   rsp_if.eased_value);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= DOG_LIMIT) begin
      $display("easing_curve_evaluator regression: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int  stall;
    bit  held;
    bit  calm;
    int  span;
    rsp_if.ready = 1'b0;
    stall = 0;
    held  = 0;
    calm  = 0;
    span  = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        span = $urandom_range(50, 250);
      end
      span--;
      if (!held && results_seen >= 150) begin
        held = 1;
        rsp_if.ready <= 1'b0;
        repeat (399) @(negedge clk_i);
      end else if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [SEL_W-1:0] sel, input logic [CTRL_W-1:0] t);
    @(negedge clk_i);
    req_if.valid        <= 1'b1;
    req_if.curve_select <= sel;
    req_if.progress     <= t;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // drop valid and let the pipeline run dry
  task automatic drain();
    hold_off(1);
    while (eased_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_points(input longint x1, input longint y1,
                              input longint x2, input longint y2);
    longint vals[4];
    vals = '{x1, y1, x2, y2};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(i);
      cfg_wdata_i <= vals[i][CTRL_W-1:0];
    end
    // an index past the last register must be dropped
    @(negedge clk_i);
    cfg_idx_i   <= CFG_IDX_W'($urandom_range(4, 7));
    cfg_wdata_i <= CTRL_W'($urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pt1_x = longint'(signed'(x1[CTRL_W-1:0]));
    pt1_y = longint'(signed'(y1[CTRL_W-1:0]));
    pt2_x = longint'(signed'(x2[CTRL_W-1:0]));
    pt2_y = longint'(signed'(y2[CTRL_W-1:0]));
  endtask

  function automatic logic [CTRL_W-1:0] random_progress();
    if ($urandom_range(0, 4) == 0) return CTRL_W'($urandom);
    return CTRL_W'($urandom_range(0, 69536) - 2000);
  endfunction

  function automatic logic [SEL_W-1:0] random_curve();
    if ($urandom_range(0, 3) == 0) return CURVE_BEZIER;
    return SEL_W'($urandom_range(0, 15));
  endfunction

  vec_t directed[] = '{
    '{CURVE_LINEAR,    18'h20000, 1, 17'd0},
    '{CURVE_LINEAR,    18'h1FFFF, 1, 17'd65536},
    '{CURVE_LINEAR,    18'd30000, 1, 17'd30000},
    '{CURVE_CUBIC_IN,  18'd0,     1, 17'd0},
    '{CURVE_CUBIC_IN,  18'd65536, 1, 17'd65536},
    '{CURVE_CUBIC_OUT, 18'd0,     1, 17'd0},
    '{CURVE_CUBIC_OUT, 18'd40000, 0, 17'd0},
    '{CURVE_SMOOTH,    18'd65536, 1, 17'd65536},
    '{CURVE_SMOOTH,    18'd32768, 0, 17'd0},
    '{CURVE_BACK,      18'd65536, 1, 17'd65536},
    '{CURVE_BACK,      18'd10000, 0, 17'd0},
    '{CURVE_OUT_CUBIC, 18'd20000, 0, 17'd0},
    '{CURVE_SPRING,    18'd0,     1, 17'd0},
    '{CURVE_SPRING,    18'd65536, 1, 17'd65536},
    '{CURVE_SPRING,    18'd1,     0, 17'd0},
    '{CURVE_SPRING,    18'd65535, 0, 17'd0},
    '{CURVE_BOUNCE,    18'd0,     1, 17'd0},
    '{CURVE_BOUNCE,    18'd65536, 1, 17'd65536},
    '{CURVE_BOUNCE,    18'd23832, 0, 17'd0},
    '{CURVE_BOUNCE,    18'd47663, 0, 17'd0},
    '{CURVE_BOUNCE,    18'd59578, 0, 17'd0},
    '{CURVE_STEP,      18'd65535, 1, 17'd0},
    '{CURVE_STEP,      18'd65536, 1, 17'd65536},
    '{CURVE_BEZIER,    18'd16384, 0, 17'd0},
    '{4'd15,           18'd65536, 1, 17'd65536}
  };

  initial begin
    longint pts[5][4];
    mismatches   = 0;
    results_seen = 0;
    idle_cycles  = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    req_if.valid        = 1'b0;
    req_if.curve_select = '0;
    req_if.progress     = '0;
    pt1_x = 0;
    pt1_y = 0;
    pt2_x = Q_ONE;
    pt2_y = Q_ONE;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].typed && eased_of(directed[i].sel, directed[i].t) !== directed[i].value) begin
        mismatches++;
        $display("%0t: table row %0d expected %0d actual %0d", $time, i,
                 directed[i].value, eased_of(directed[i].sel, directed[i].t));
      end
      send_request(directed[i].sel, directed[i].t);
      hold_off(gap_len());
    end
    drain();

    pts[0] = '{27525, 0, 38011, 65536};
    pts[1] = '{-131072, 131071, 131071, -131072};
    pts[2] = '{131071, -131072, -131072, 131071};
    pts[3] = '{0, 0, 0, 0};
    pts[4] = '{$urandom_range(0, 65536), longint'($urandom_range(0, 262143)) - 131072,
               $urandom_range(0, 65536), longint'($urandom_range(0, 262143)) - 131072};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_points(pts[ph-1][0], pts[ph-1][1], pts[ph-1][2], pts[ph-1][3]);
      for (int n = 0; n < 105; n++) begin
        send_request(random_curve(), random_progress());
        hold_off(gap_len());
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("easing_curve_evaluator regression: pass");
    end else begin
      $display("easing_curve_evaluator regression: fail");
    end
    $finish;
  end

endmodule
